// File: sv/spm_pkg.sv
package spm_pkg;

  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned DEF_COUNT_BITS  = 16;

  // Decay factor is unsigned Q0.16.
  localparam int unsigned     DECAY_W     = 16;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd62259;

  // Item kinds carried on the input tuser.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_L,
    ST_SQ_R,
    ST_ACC_R,
    ST_HOLD_L,
    ST_HOLD_R,
    ST_HOLD_W,
    ST_RMS_L_GO,
    ST_RMS_L_WAIT,
    ST_RMS_R_GO,
    ST_RMS_R_WAIT,
    ST_OUT
  } spm_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } spm_ds_state_e;

  // Handshake between the sequencer and the divide / square root unit.
  typedef struct packed {
    logic start;
  } spm_ds_req_t;

  typedef struct packed {
    logic done;
  } spm_ds_rsp_t;

endpackage

// File: sv/spm_mul.sv
module spm_mul #(
  parameter int unsigned A_W = 23,
  parameter int unsigned B_W = 23
) (
  input  logic               clk_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;
  logic [A_W+B_W-1:0] p_d;

  assign p_d = (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: sv/spm_divsqrt.sv
module spm_divsqrt #(
  parameter int unsigned SUM_W      = 62,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spm_pkg::spm_ds_req_t     req_i,
  input  logic [SUM_W-1:0]         dividend_i,
  input  logic [COUNT_BITS-1:0]    divisor_i,
  output spm_pkg::spm_ds_rsp_t     rsp_o,
  output logic [(SUM_W+1)/2-1:0]   root_o
);

  localparam int unsigned SQRT_W = (SUM_W + 1) / 2;
  localparam int unsigned XW     = 2 * SQRT_W;
  localparam int unsigned SUB_W  = (COUNT_BITS + 1 > SQRT_W + 2) ? COUNT_BITS + 1 : SQRT_W + 2;
  localparam int unsigned STEP_W = $clog2(XW);

  spm_pkg::spm_ds_state_e state_q, state_d;

  logic [XW-1:0]         x_q, x_d;
  logic [SUB_W-1:0]      rem_q, rem_d;
  logic [SQRT_W-1:0]     root_q, root_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic [STEP_W-1:0]     step_q, step_d;

  logic             in_div;
  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W:0]   sub_res;
  logic             borrow;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spm_pkg::DS_IDLE: begin
        if (req_i.start) begin
          state_d = spm_pkg::DS_DIV;
        end
      end
      spm_pkg::DS_DIV: begin
        if (step_q == '0) begin
          state_d = spm_pkg::DS_SQRT;
        end
      end
      spm_pkg::DS_SQRT: begin
        if (step_q == '0) begin
          state_d = spm_pkg::DS_DONE;
        end
      end
      spm_pkg::DS_DONE: begin
        state_d = spm_pkg::DS_IDLE;
      end
      default: begin
        state_d = spm_pkg::DS_IDLE;
      end
    endcase
  end

  // Outputs and operand selection for the shared subtractor.
  always_comb begin
    rsp_o.done = 1'b0;
    in_div     = 1'b0;
    unique case (state_q)
      spm_pkg::DS_DIV: begin
        in_div = 1'b1;
      end
      spm_pkg::DS_DONE: begin
        rsp_o.done = 1'b1;
      end
      default: begin
        in_div = 1'b0;
      end
    endcase
  end

  // Restoring division brings in one dividend bit a step; the square root
  // brings in two bits a step and tries the digit one.
  always_comb begin
    if (in_div) begin
      sub_a = {rem_q[SUB_W-2:0], x_q[XW-1]};
      sub_b = SUB_W'(div_q);
    end else begin
      sub_a = {rem_q[SUB_W-3:0], x_q[XW-1:XW-2]};
      sub_b = SUB_W'({root_q, 2'b01});
    end
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[SUB_W];

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_d  = div_q;
    step_d = step_q;
    case (state_q)
      spm_pkg::DS_IDLE: begin
        if (req_i.start) begin
          x_d    = XW'(dividend_i);
          rem_d  = '0;
          root_d = '0;
          div_d  = divisor_i;
          step_d = STEP_W'(XW - 1);
        end
      end
      spm_pkg::DS_DIV: begin
        rem_d  = borrow ? sub_a : sub_res[SUB_W-1:0];
        x_d    = {x_q[XW-2:0], ~borrow};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rem_d  = '0;
          step_d = STEP_W'(SQRT_W - 1);
        end
      end
      spm_pkg::DS_SQRT: begin
        rem_d  = borrow ? sub_a : sub_res[SUB_W-1:0];
        x_d    = {x_q[XW-3:0], 2'b00};
        root_d = {root_q[SQRT_W-2:0], ~borrow};
        step_d = step_q - 1'b1;
      end
      default: begin
        step_d = step_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spm_pkg::DS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  assign root_o = root_q;

endmodule

// File: sv/stereo_peak_rms_level_meter_core.sv
// Stereo peak / rms level meter with a decaying peak hold, one item at a time.
// A sample beat is taken while the block is idle; it is ready again after states SQ_L,
// SQ_R and ACC_R, in which one shared multiplier squares left, then right, into the sums.
// A report beat runs the bit-serial divide and square root unit once per channel
// before its result is loaded.
// Asynchronous active-low reset clears all meter state and the output valid, and loads the decay reset value.
module stereo_peak_rms_level_meter_core #(
  parameter int unsigned SAMPLE_BITS = spm_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = spm_pkg::DEF_COUNT_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // Configuration: hold decay factor, unsigned Q0.16.
  input  logic                                          cfg_we_i,
  input  logic [spm_pkg::DECAY_W-1:0]                   cfg_wdata_i,
  // Input stream.
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // tdata, lowest bit up: left_sample, right_sample, zero fill.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,
  // tuser: mode (0 = sample pair, 1 = report).
  input  logic                                          s_axis_tuser,
  // Result stream.
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // tdata, lowest bit up: peak_left, rms_left, hold_left, peak_right,
  // rms_right, hold_right, zero fill.
  output logic [((6*(SAMPLE_BITS-1)+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int unsigned MAG_W      = SAMPLE_BITS - 1;
  localparam int unsigned SUM_FULL   = 2 * MAG_W + COUNT_BITS;
  localparam int unsigned SUM_W      = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int unsigned MUL_B_W    = (MAG_W > spm_pkg::DECAY_W) ? MAG_W : spm_pkg::DECAY_W;
  localparam int unsigned PROD_W     = MAG_W + MUL_B_W;
  localparam int unsigned SQRT_W     = (SUM_W + 1) / 2;
  localparam int unsigned OUT_DATA_W = ((6 * MAG_W + 7) / 8) * 8;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  spm_pkg::spm_state_e state_q, state_d;

  logic [spm_pkg::DECAY_W-1:0] hold_decay_q;

  // Meter state.
  logic [MAG_W-1:0]      peak_l_q, peak_l_d, peak_r_q, peak_r_d;
  logic [SUM_W-1:0]      sumsq_l_q, sumsq_l_d, sumsq_r_q, sumsq_r_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [MAG_W-1:0]      hold_l_q, hold_l_d, hold_r_q, hold_r_d;

  // Working registers.
  logic [MAG_W-1:0] mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic [MAG_W-1:0] rms_l_q, rms_l_d, rms_r_q, rms_r_d;

  // Output register.
  logic             out_valid_q;
  logic [MAG_W-1:0] o_peak_l_q, o_rms_l_q, o_hold_l_q;
  logic [MAG_W-1:0] o_peak_r_q, o_rms_r_q, o_hold_r_q;

  // Sequencer controls.
  logic               in_accept;
  logic               report_load;
  logic               acc_l_en, acc_r_en;
  logic               hold_l_en, hold_r_en;
  logic               rms_l_en, rms_r_en;
  logic               rms_sel_r;
  logic [MAG_W-1:0]   mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  spm_pkg::spm_ds_req_t ds_req;
  spm_pkg::spm_ds_rsp_t ds_rsp;
  logic [SQRT_W-1:0]    ds_root;

  // Sample magnitudes; the most negative code saturates to the largest magnitude.
  logic [SAMPLE_BITS-1:0] left_raw, right_raw;
  logic [SAMPLE_BITS-1:0] abs_l, abs_r;
  logic [MAG_W-1:0]       mag_l, mag_r;

  assign left_raw  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign right_raw = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_comb begin
    abs_l = left_raw[SAMPLE_BITS-1]  ? (~left_raw + 1'b1)  : left_raw;
    abs_r = right_raw[SAMPLE_BITS-1] ? (~right_raw + 1'b1) : right_raw;
    mag_l = abs_l[SAMPLE_BITS-1] ? MAG_MAX : abs_l[MAG_W-1:0];
    mag_r = abs_r[SAMPLE_BITS-1] ? MAG_MAX : abs_r[MAG_W-1:0];
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spm_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser == spm_pkg::MODE_REPORT) ? spm_pkg::ST_HOLD_L
                                                           : spm_pkg::ST_SQ_L;
        end
      end
      spm_pkg::ST_SQ_L:     state_d = spm_pkg::ST_SQ_R;
      spm_pkg::ST_SQ_R:     state_d = spm_pkg::ST_ACC_R;
      spm_pkg::ST_ACC_R:    state_d = spm_pkg::ST_IDLE;
      spm_pkg::ST_HOLD_L:   state_d = spm_pkg::ST_HOLD_R;
      spm_pkg::ST_HOLD_R:   state_d = spm_pkg::ST_HOLD_W;
      spm_pkg::ST_HOLD_W:   state_d = spm_pkg::ST_RMS_L_GO;
      spm_pkg::ST_RMS_L_GO: state_d = spm_pkg::ST_RMS_L_WAIT;
      spm_pkg::ST_RMS_L_WAIT: begin
        if (ds_rsp.done) begin
          state_d = spm_pkg::ST_RMS_R_GO;
        end
      end
      spm_pkg::ST_RMS_R_GO: state_d = spm_pkg::ST_RMS_R_WAIT;
      spm_pkg::ST_RMS_R_WAIT: begin
        if (ds_rsp.done) begin
          state_d = spm_pkg::ST_OUT;
        end
      end
      spm_pkg::ST_OUT: begin
        if (report_load) begin
          state_d = spm_pkg::ST_IDLE;
        end
      end
      default: state_d = spm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. The multiplier squares a magnitude or scales a hold; its
  // product is registered, so the cycle after a multiply consumes it.
  always_comb begin
    s_axis_tready = 1'b0;
    report_load   = 1'b0;
    acc_l_en      = 1'b0;
    acc_r_en      = 1'b0;
    hold_l_en     = 1'b0;
    hold_r_en     = 1'b0;
    rms_l_en      = 1'b0;
    rms_r_en      = 1'b0;
    rms_sel_r     = 1'b0;
    ds_req.start  = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      spm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      spm_pkg::ST_SQ_L: begin
        mul_a = mag_l_q;
        mul_b = MUL_B_W'(mag_l_q);
      end
      spm_pkg::ST_SQ_R: begin
        mul_a    = mag_r_q;
        mul_b    = MUL_B_W'(mag_r_q);
        acc_l_en = 1'b1;
      end
      spm_pkg::ST_ACC_R: begin
        acc_r_en = 1'b1;
      end
      spm_pkg::ST_HOLD_L: begin
        mul_a = hold_l_q;
        mul_b = MUL_B_W'(hold_decay_q);
      end
      spm_pkg::ST_HOLD_R: begin
        mul_a     = hold_r_q;
        mul_b     = MUL_B_W'(hold_decay_q);
        hold_l_en = 1'b1;
      end
      spm_pkg::ST_HOLD_W: begin
        hold_r_en = 1'b1;
      end
      spm_pkg::ST_RMS_L_GO: begin
        ds_req.start = 1'b1;
      end
      spm_pkg::ST_RMS_L_WAIT: begin
        rms_l_en = ds_rsp.done;
      end
      spm_pkg::ST_RMS_R_GO: begin
        ds_req.start = 1'b1;
        rms_sel_r    = 1'b1;
      end
      spm_pkg::ST_RMS_R_WAIT: begin
        rms_sel_r = 1'b1;
        rms_r_en  = ds_rsp.done;
      end
      spm_pkg::ST_OUT: begin
        // The result register is free once the previous result has been taken.
        report_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  spm_mul #(
    .A_W (MAG_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  spm_divsqrt #(
    .SUM_W      (SUM_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ds_req),
    .dividend_i (rms_sel_r ? sumsq_r_q : sumsq_l_q),
    .divisor_i  (count_q),
    .rsp_o      (ds_rsp),
    .root_o     (ds_root)
  );

  // Shared datapath: one saturating adder for both sums, one max for both holds.
  logic [SUM_W-1:0]  acc_in;
  logic [SUM_W:0]    acc_sum;
  logic [SUM_W-1:0]  acc_sat;
  logic [MAG_W-1:0]  decayed;
  logic [MAG_W-1:0]  hold_peak;
  logic [MAG_W-1:0]  hold_new;
  logic [MAG_W-1:0]  rms_val;

  always_comb begin
    acc_in    = acc_r_en ? sumsq_r_q : sumsq_l_q;
    acc_sum   = {1'b0, acc_in} + {1'b0, SUM_W'(prod[2*MAG_W-1:0])};
    acc_sat   = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
    decayed   = prod[spm_pkg::DECAY_W +: MAG_W];
    hold_peak = hold_r_en ? peak_r_q : peak_l_q;
    hold_new  = (hold_peak > decayed) ? hold_peak : decayed;
    // An empty window reads as silence; an oversized root only follows saturation.
    if (count_q == '0) begin
      rms_val = '0;
    end else if (ds_root > SQRT_W'(MAG_MAX)) begin
      rms_val = MAG_MAX;
    end else begin
      rms_val = ds_root[MAG_W-1:0];
    end
  end

  always_comb begin
    peak_l_d  = peak_l_q;
    peak_r_d  = peak_r_q;
    sumsq_l_d = sumsq_l_q;
    sumsq_r_d = sumsq_r_q;
    count_d   = count_q;
    hold_l_d  = hold_l_q;
    hold_r_d  = hold_r_q;
    mag_l_d   = mag_l_q;
    mag_r_d   = mag_r_q;
    rms_l_d   = rms_l_q;
    rms_r_d   = rms_r_q;

    if (in_accept && (s_axis_tuser == spm_pkg::MODE_SAMPLE)) begin
      mag_l_d = mag_l;
      mag_r_d = mag_r;
      if (mag_l > peak_l_q) begin
        peak_l_d = mag_l;
      end
      if (mag_r > peak_r_q) begin
        peak_r_d = mag_r;
      end
      if (count_q != {COUNT_BITS{1'b1}}) begin
        count_d = count_q + 1'b1;
      end
    end
    if (acc_l_en) begin
      sumsq_l_d = acc_sat;
    end
    if (acc_r_en) begin
      sumsq_r_d = acc_sat;
    end
    if (hold_l_en) begin
      hold_l_d = hold_new;
    end
    if (hold_r_en) begin
      hold_r_d = hold_new;
    end
    if (rms_l_en) begin
      rms_l_d = rms_val;
    end
    if (rms_r_en) begin
      rms_r_d = rms_val;
    end
    // The report window closes when its result moves into the output register.
    if (report_load) begin
      peak_l_d  = '0;
      peak_r_d  = '0;
      sumsq_l_d = '0;
      sumsq_r_d = '0;
      count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spm_pkg::ST_IDLE;
      hold_decay_q <= spm_pkg::DECAY_RESET;
      peak_l_q     <= '0;
      peak_r_q     <= '0;
      sumsq_l_q    <= '0;
      sumsq_r_q    <= '0;
      count_q      <= '0;
      hold_l_q     <= '0;
      hold_r_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      peak_l_q  <= peak_l_d;
      peak_r_q  <= peak_r_d;
      sumsq_l_q <= sumsq_l_d;
      sumsq_r_q <= sumsq_r_d;
      count_q   <= count_d;
      hold_l_q  <= hold_l_d;
      hold_r_q  <= hold_r_d;
      if (cfg_we_i) begin
        hold_decay_q <= cfg_wdata_i;
      end
      if (report_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_l_q <= mag_l_d;
    mag_r_q <= mag_r_d;
    rms_l_q <= rms_l_d;
    rms_r_q <= rms_r_d;
    if (report_load) begin
      o_peak_l_q <= peak_l_q;
      o_rms_l_q  <= rms_l_q;
      o_hold_l_q <= hold_l_q;
      o_peak_r_q <= peak_r_q;
      o_rms_r_q  <= rms_r_q;
      o_hold_r_q <= hold_r_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({o_hold_r_q, o_rms_r_q, o_peak_r_q,
                                      o_hold_l_q, o_rms_l_q, o_peak_l_q});

  // The divide / square root unit only finishes while the sequencer waits for it.
  a_ds_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_rsp.done |-> (state_q == spm_pkg::ST_RMS_L_WAIT || state_q == spm_pkg::ST_RMS_R_WAIT))
    else $error("divide/sqrt done outside a wait state");

  // Once the holds are updated, each hold is at least the window peak.
  a_hold_covers_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spm_pkg::ST_RMS_L_GO) |-> (hold_l_q >= peak_l_q && hold_r_q >= peak_r_q))
    else $error("peak hold below peak after update");

  // The left sum never decreases on accumulation.
  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_l_en |=> (sumsq_l_q >= $past(sumsq_l_q)))
    else $error("left sum of squares decreased");

  // Loading a result closes the window.
  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_load |=> (count_q == '0 && sumsq_l_q == '0 && sumsq_r_q == '0 && m_axis_tvalid))
    else $error("window not cleared on report");

endmodule
